// ===== hw/rtl/tkps_pkg.sv =====
package tkps_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int VAL_W     = 32;
   localparam int PC_W      = 6;
   localparam int KEEP_W    = 5;

   localparam logic [KEEP_W-1:0] KEEP_RST = 5'd16;

   // word kinds on the request channel
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DRAIN
   } cell_op_type;

   // broadcast to every cell of the row
   typedef struct packed {
      cell_op_type            op;
      logic [VAL_W-1:0]       new_value;
      logic [PC_W-1:0]        new_pc;
   } cell_ctl_type;

   function automatic logic [PC_W-1:0] ones_count(input logic [VAL_W-1:0] v);
      logic [PC_W-1:0] c;
      c = '0;
      for (int i = 0; i < VAL_W; i++) begin
         c = c + PC_W'(v[i]);
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/tkps_req_if.sv =====
interface tkps_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic signed [tkps_pkg::VAL_W-1:0]   value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

// ===== hw/rtl/tkps_rsp_if.sv =====
interface tkps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tkps_pkg::VAL_W-1:0]   value_res;
   logic                                is_last;

   modport source (output valid, output value_res, output is_last, input ready);
   modport sink   (input valid, input value_res, input is_last, output ready);
endinterface

// ===== hw/rtl/topk_popcount_select_top.sv =====
// channel   dir  handshake      word contents
// req_chan  in   valid/ready    kind (0 data, 1 end), value (s32)
// rsp_chan  out  valid/ready    value_res (s32), is_last
// csr       in   csr_wr_en      csr_wr_data = keep_count (5 bits)
//
// A data word is taken while idle: every cell compares the newcomer in parallel
// and the row shifts right by one below the insertion point.
// An end word sends k words, k = min(keep_count, DEPTH): zeros for the unfilled slots
// first, then the row drains one entry a cycle into the output register; req ready is low.
// Reset (synchronous, active high) empties the row and sets keep_count 16.
// Output stalls hold the drain; a last word may wait while data words are taken.
module topk_popcount_select_top #(
   parameter int DEPTH = tkps_pkg::DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   tkps_req_if.sink                      req_chan,
   tkps_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [tkps_pkg::KEEP_W-1:0]   csr_wr_data
);
   import tkps_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);          // count width, holds DEPTH
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [KEEP_W-1:0]       keep_ff, keep_in;
   logic [CW-1:0]           count_ff, count_in;     // entries held
   logic [CW-1:0]           zeros_ff, zeros_in;     // leading zero words to send
   logic [CW-1:0]           held_ff, held_in;       // held words still to send
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [CW-1:0]           k_w, held_w, limit_w;
   logic [CW:0]             total_left_w;
   logic                    req_acc_w, worst_above_w, insert_w, load_w, drain_w;
   cell_ctl_type            cell_ctl;
   logic [DEPTH-1:0]        above_vec;
   logic signed [VAL_W-1:0] cell_value [DEPTH];
   logic [PC_W-1:0]         cell_pc [DEPTH];

   // effective k: keep_count saturated to the row length
   assign k_w = (32'(keep_ff) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(keep_ff);
   assign held_w = (count_ff < k_w) ? count_ff : k_w;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc_w      = req_chan.valid && req_chan.ready;

   // row full: newcomer may only displace the worst held entry
   assign worst_above_w = (count_ff != '0) && above_vec[IW'(count_ff - CW'(1))];
   assign insert_w = req_acc_w && (req_chan.kind == KIND_DATA)
                     && ((count_ff < k_w) || worst_above_w);
   // last cell taking part in the insertion
   assign limit_w = (count_ff < k_w) ? count_ff : count_ff - CW'(1);

   assign load_w       = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);
   assign drain_w      = load_w && (zeros_ff == '0);
   assign total_left_w = {1'b0, zeros_ff} + {1'b0, held_ff};

   always_comb begin
      cell_ctl.new_value = req_chan.value;
      cell_ctl.new_pc    = ones_count(req_chan.value);
      if (insert_w) begin
         cell_ctl.op = CELL_INSERT;
      end else if (drain_w) begin
         cell_ctl.op = CELL_DRAIN;
      end else begin
         cell_ctl.op = CELL_HOLD;
      end
   end

   // sorted row, best entry in cell 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                    left_above;
      logic signed [VAL_W-1:0] left_value, right_value;
      logic [PC_W-1:0]         left_pc, right_pc;

      if (i == 0) begin : g_head
         assign left_above = 1'b0;
         assign left_value = '0;
         assign left_pc    = '0;
      end else begin : g_body
         assign left_above = above_vec[i-1];
         assign left_value = cell_value[i-1];
         assign left_pc    = cell_pc[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_value = '0;
         assign right_pc    = '0;
      end else begin : g_next
         assign right_value = cell_value[i+1];
         assign right_pc    = cell_pc[i+1];
      end

      tkps_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .occupied    (CW'(i) < count_ff),
         .in_range    (CW'(i) <= limit_w),
         .left_above  (left_above),
         .left_value  (left_value),
         .left_pc     (left_pc),
         .right_value (right_value),
         .right_pc    (right_pc),
         .value       (cell_value[i]),
         .pc          (cell_pc[i]),
         .above       (above_vec[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      keep_in      = csr_wr_en ? csr_wr_data : keep_ff;
      count_in     = count_ff;
      zeros_in     = zeros_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc_w) begin
               if (req_chan.kind == KIND_END) begin
                  if (k_w == '0) begin
                     count_in = '0;                // nothing to send, just clear
                  end else begin
                     zeros_in = k_w - held_w;
                     held_in  = held_w;
                     state_in = ST_EMIT;
                  end
               end else if (insert_w && (count_ff < k_w)) begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         ST_EMIT: begin
            if (load_w) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = (total_left_w == (CW+1)'(1));
               if (zeros_ff != '0) begin
                  rsp_value_in = '0;
                  zeros_in     = zeros_ff - CW'(1);
               end else begin
                  rsp_value_in = cell_value[0];
                  held_in      = held_ff - CW'(1);
               end
               if (total_left_w == (CW+1)'(1)) begin
                  state_in = ST_IDLE;
                  count_in = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         keep_ff      <= KEEP_RST;
         count_ff     <= '0;
         zeros_ff     <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         keep_ff      <= keep_in;
         count_ff     <= count_in;
         zeros_ff     <= zeros_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.value_res = rsp_value_ff;
   assign rsp_chan.is_last   = rsp_last_ff;

endmodule

// ===== hw/rtl/tkps_cell.sv =====
module tkps_cell (
   input  logic                              clock,
   input  tkps_pkg::cell_ctl_type            ctl,
   input  logic                              occupied,
   input  logic                              in_range,
   input  logic                              left_above,
   input  logic signed [tkps_pkg::VAL_W-1:0] left_value,
   input  logic [tkps_pkg::PC_W-1:0]         left_pc,
   input  logic signed [tkps_pkg::VAL_W-1:0] right_value,
   input  logic [tkps_pkg::PC_W-1:0]         right_pc,
   output logic signed [tkps_pkg::VAL_W-1:0] value,
   output logic [tkps_pkg::PC_W-1:0]         pc,
   output logic                              above
);
   import tkps_pkg::*;

   logic signed [VAL_W-1:0] value_ff, value_in;
   logic [PC_W-1:0]         pc_ff, pc_in;

   // newcomer outranks this entry; an empty slot is always outranked
   assign above = !occupied
                  || (ctl.new_pc > pc_ff)
                  || ((ctl.new_pc == pc_ff) && ($signed(ctl.new_value) > value_ff));

   always_comb begin
      value_in = value_ff;
      pc_in    = pc_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (in_range) begin
               if (left_above) begin
                  value_in = left_value;
                  pc_in    = left_pc;
               end else if (above) begin
                  value_in = $signed(ctl.new_value);
                  pc_in    = ctl.new_pc;
               end
            end
         end
         CELL_DRAIN: begin
            value_in = right_value;
            pc_in    = right_pc;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      pc_ff    <= pc_in;
   end

   assign value = value_ff;
   assign pc    = pc_ff;

endmodule

// ===== hw/rtl/tkps_checker.sv =====
module tkps_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_kind,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);
   import tkps_pkg::*;

   // stalled word stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_last))
      else $error("rsp word dropped under stall");

   // a data word never starts a result run
   a_data_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_DATA) && !rsp_valid |=> !rsp_valid)
      else $error("result after data word");

   // input closed until the last word of a run is loaded
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input open mid run");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind topk_popcount_select_top tkps_checker u_tkps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_kind  (req_chan.kind),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_last  (rsp_chan.is_last)
);

// ===== verif/topk_popcount_select_top_tb.sv =====
`timescale 1ns / 1ps

import tkps_pkg::*;

// Tracks the best-ranked values the block should be holding and the
// result words due from it, oldest first.
class topk_select_board;
   typedef struct packed {
      logic signed [VAL_W-1:0] value_res;
      logic                    is_last;
   } selection_type;

   logic [VAL_W-1:0]  kept [DEPTH_DEF];
   int unsigned       held;
   logic [KEEP_W-1:0] keep_reg;
   selection_type     due_q [$];
   int unsigned       mismatches;

   function new();
      keep_reg   = KEEP_RST;
      held       = 0;
      mismatches = 0;
      foreach (kept[i]) kept[i] = '0;
   endfunction

   function void write_keep(logic [KEEP_W-1:0] v);
      keep_reg = v;
   endfunction

   function int unsigned bits_set(logic [VAL_W-1:0] v);
      int unsigned n;
      n = 0;
      for (int i = 0; i < VAL_W; i++) n += v[i];
      return n;
   endfunction

   // more ones wins, then the larger signed value
   function bit outranks(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      int unsigned ca, cb;
      ca = bits_set(a);
      cb = bits_set(b);
      if (ca != cb) return ca > cb;
      return $signed(a) > $signed(b);
   endfunction

   // sorted insert over the first n entries, best first
   function void place(logic [VAL_W-1:0] v, int unsigned n);
      int unsigned pos;
      pos = n;
      while (pos > 0 && outranks(v, kept[pos-1])) begin
         kept[pos] = kept[pos-1];
         pos--;
      end
      kept[pos] = v;
   endfunction

   function void note_word(logic kind, logic [VAL_W-1:0] v);
      int unsigned   k, shown, zeros;
      selection_type s;
      k = (keep_reg > DEPTH_DEF) ? DEPTH_DEF : keep_reg;
      if (kind == KIND_DATA) begin
         if (held < k) begin
            place(v, held);
            held++;
         end else if (held > 0 && outranks(v, kept[held-1])) begin
            place(v, held - 1);
         end
      end else begin
         shown = (held < k) ? held : k;
         zeros = k - shown;
         for (int unsigned i = 0; i < k; i++) begin
            if (i < zeros) s.value_res = '0;
            else s.value_res = kept[i-zeros];
            s.is_last = (i + 1 == k);
            due_q.push_back(s);
         end
         held = 0;
      end
   endfunction

   function void check_selection(logic signed [VAL_W-1:0] got_value, logic got_last);
      selection_type want;
      if (due_q.size() == 0) begin
         if (mismatches < 10)
            $display("unexpected result word: value_res=%0d (%h) is_last=%0b",
                     got_value, got_value, got_last);
         mismatches++;
         return;
      end
      want = due_q.pop_front();
      if (got_value !== want.value_res || got_last !== want.is_last) begin
         if (mismatches < 10)
            $display("mismatch: want %0d (%h) last %0b, got %0d (%h) last %0b",
                     want.value_res, want.value_res, want.is_last,
                     got_value, got_value, got_last);
         mismatches++;
      end
   endfunction

   function int unsigned pending();
      return due_q.size();
   endfunction
endclass

module topk_popcount_select_top_tb;

   // generous ceiling; the slowest legal run needs a small fraction of it
   localparam int CYCLE_LIMIT   = 300000;
   // settling margin after the result queue is empty, sized from the row depth
   localparam int SETTLE_CYCLES = DEPTH_DEF + 8;
   localparam int RANDOM_ITEMS  = 420;
   localparam int PHASES        = 8;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [KEEP_W-1:0] csr_wr_data;

   tkps_req_if req_chan_if ();
   tkps_rsp_if rsp_chan_if ();

   // idling odds, percent per cycle, changed between phases
   int unsigned src_idle_pct;
   int unsigned snk_stall_pct;

   topk_select_board  board;
   logic [VAL_W-1:0]  tie_pool [6];
   logic [KEEP_W-1:0] phase_keep [PHASES];
   int unsigned       cycles;
   int unsigned       fails;

   topk_popcount_select_top #(
      .DEPTH (DEPTH_DEF)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan_if),
      .rsp_chan    (rsp_chan_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offer one word. Idle cycles come first so that valid is never dropped
   // and raised in the same step; junk rides on the bus while valid is low.
   task automatic push_word(logic kind, logic [VAL_W-1:0] v);
      while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
         req_chan_if.valid <= 1'b0;
         req_chan_if.kind  <= 1'($urandom_range(0, 1));
         req_chan_if.value <= $urandom;
         @(posedge clock);
      end
      req_chan_if.valid <= 1'b1;
      req_chan_if.kind  <= kind;
      req_chan_if.value <= v;
      do @(posedge clock); while (req_chan_if.ready !== 1'b1);
      board.note_word(kind, v);
   endtask

   // Drain everything due, then give the row time to finish any data word
   // that left no result behind.
   task automatic settle();
      req_chan_if.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_keep(logic [KEEP_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.write_keep(v);
   endtask

   // Mix of shapes: tie-prone pool, single bits, single holes, sparse,
   // dense and plain random words.
   function automatic logic [VAL_W-1:0] pick_value();
      logic [VAL_W-1:0] v;
      case ($urandom_range(0, 5))
         0: v = tie_pool[$urandom_range(0, 5)];
         1: v = 32'h1 << $urandom_range(0, 31);
         2: v = ~(32'h1 << $urandom_range(0, 31));
         3: v = $urandom & $urandom & $urandom;
         4: v = $urandom | $urandom;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Random words: mostly data runs closed by an end word now and then.
   task automatic random_run(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) push_word(KIND_END, $urandom);
         else push_word(KIND_DATA, pick_value());
      end
   endtask

   // Result side: sample at the edge, then choose ready for the next cycle.
   initial begin
      rsp_chan_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan_if.valid === 1'b1 && rsp_chan_if.ready === 1'b1)
            board.check_selection(rsp_chan_if.value_res, rsp_chan_if.is_last);
         rsp_chan_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
   end

   // Watchdog
   initial begin
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      board         = new();
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_chan_if.valid <= 1'b0;
      req_chan_if.kind  <= KIND_DATA;
      req_chan_if.value <= '0;

      // pool: extremes plus two random words, so ties and repeats turn up
      tie_pool[0] = 32'h0000_0000;
      tie_pool[1] = 32'hFFFF_FFFF;
      tie_pool[2] = 32'h8000_0000;
      tie_pool[3] = 32'h7FFF_FFFF;
      tie_pool[4] = $urandom;
      tie_pool[5] = $urandom;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // default keep of 16: extremes, equal counts split by sign, a
      // repeated value, and leading zeros for the unfilled slots
      push_word(KIND_DATA, 32'h0000_0000);
      push_word(KIND_DATA, 32'hFFFF_FFFF);
      push_word(KIND_DATA, 32'h8000_0000);
      push_word(KIND_DATA, 32'h7FFF_FFFF);
      push_word(KIND_DATA, 32'h0000_0001);
      push_word(KIND_DATA, 32'h0000_0002);
      push_word(KIND_DATA, 32'h0000_0002);
      push_word(KIND_END,  32'h0000_0000);
      // end on an empty store: all zeros
      push_word(KIND_END,  32'hFFFF_FFFF);

      // small keep: full store, replacement of the worst, tie on count
      settle();
      write_keep(5'd3);
      push_word(KIND_DATA, 32'h0000_0005);
      push_word(KIND_DATA, 32'h0000_0003);
      push_word(KIND_DATA, 32'h0000_0006);
      push_word(KIND_DATA, 32'h0000_0007);
      push_word(KIND_END,  32'h0000_0000);

      // keep of zero: data dropped, end emits nothing
      settle();
      write_keep(5'd0);
      push_word(KIND_DATA, 32'h0000_DEAD);
      push_word(KIND_END,  32'h0000_0000);

      // keep lowered while more values are held than it allows
      settle();
      write_keep(5'd8);
      push_word(KIND_DATA, 32'h0000_000F);
      push_word(KIND_DATA, 32'h0000_00F0);
      push_word(KIND_DATA, 32'hFF00_0000);
      push_word(KIND_DATA, 32'h0000_0001);
      settle();
      write_keep(5'd2);
      push_word(KIND_DATA, 32'h0000_0003);
      push_word(KIND_END,  32'h0000_0000);

      // keep above the row depth saturates
      settle();
      write_keep(5'd31);
      push_word(KIND_DATA, 32'hFFFF_FFFF);
      push_word(KIND_END,  32'h0000_0000);

      // --- random phases ---
      // idling modes cycle: none, sender idle, receiver stalling, both light
      phase_keep    = '{5'd16, 5'd1, 5'd9, 5'd31, 5'd7, 5'd2, 5'd17, 5'd0};
      phase_keep[2] = 5'($urandom_range(2, 15));
      phase_keep[7] = 5'($urandom_range(0, 31));
      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_keep(phase_keep[p]);
         case (p % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 87; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 87; end
            default: begin src_idle_pct = 8; snk_stall_pct = 8; end
         endcase
         random_run(RANDOM_ITEMS / PHASES);
      end

      // flush whatever is still held
      push_word(KIND_END, 32'h0000_0000);
      settle();

      fails = board.mismatches + board.pending();
      if (board.pending() != 0)
         $display("%0d expected result words never arrived", board.pending());
      if (fails == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
